/* rtl/core/tcca_pkg.sv */
// Package for the tile completion claim aggregator core.
// Holds the op codes, controller states and controller/datapath interface structs.
package tcca_pkg;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_START  = 3'd1,
    OP_CLAIM  = 3'd2,
    OP_END    = 3'd3,
    OP_COMMIT = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_LOOK,
    ST_RD,
    ST_CHECK,
    ST_ID_SCAN,
    ST_ACCUM,
    ST_SEQ_SCAN,
    ST_CLEAR,
    ST_EMIT,
    ST_EMIT_WAIT,
    ST_WR_COMMIT
  } state_e;

  localparam logic [6:0] CountMax = 7'd127;

  typedef struct packed {
    logic load_in;      // capture the accepted item
    logic tbl_rd;       // read the pending table at the captured index
    logic tbl_wr;       // write the captured item into the table
    logic tbl_clr;      // empty the entry at the captured index
    logic start_batch;  // latch epoch and claim time, clear aggregates
    logic clear_valid;  // clear step: sets clear_done through a register
    logic id_step;      // compare one dedupe entry, advance pointer
    logic id_record;    // record id or flag overflow
    logic accum;        // update aggregates
    logic seq_step;     // compare one sequence entry, advance pointer
    logic seq_record;   // append the sequence
    logic emit_load;    // load the output register with result k
    logic emit_next;    // advance the result index
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic claim_ok;     // live entry with matching generation and epoch
    logic commit_ok;
    logic id_done;      // id scan finished
    logic id_hit;
    logic seq_done;
    logic seq_hit;
    logic emit_last;
    logic clear_done;
    op_e  op;
  } sts_t;

endpackage

/* rtl/core/tile_completion_claim_aggregator_core.sv */
// Tile completion claim aggregator core: top level joining controller and datapath.
// Input is accepted only in the idle state; each transfer is processed before the next one.
// A claim scans the dedupe store and the sequence list serially; an end emits its results in turn.
// End results are loaded from the emit state, after the lookup state; a held output register stalls the run.
// Reset is asynchronous, active low; the table reads empty and input opens once the clear state ends.
// Depends on tcca_pkg, tcca_ctrl and tcca_dp.
module tile_completion_claim_aggregator_core #(
  parameter int TILE_SLOTS  = 256,
  parameter int CLAIM_SLOTS = 64,
  parameter int SEQ_SLOTS   = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[2:0], tile_index[18:3], generation[82:19], cmpl_tag[146:83],
  // epoch[210:147], time_ns[274:211], input_seq[338:275], zero pad
  input  logic [343:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tiles_claimed[6:0], timed_count[13:7], age_sum_ns[77:14], oldest_ns[141:78],
  // newest_ns[205:142], seq_value[269:206], zero pad
  output logic [271:0] m_axis_tdata,
  // seq_valid[0], set_overflow[1]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  tcca_pkg::cmd_t cmd;
  tcca_pkg::sts_t sts;

  tcca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (m_axis_tvalid && !m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcca_dp #(
    .TILE_SLOTS  (TILE_SLOTS),
    .CLAIM_SLOTS (CLAIM_SLOTS),
    .SEQ_SLOTS   (SEQ_SLOTS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_i               (s_axis_tdata[2:0]),
    .tile_index_i       (s_axis_tdata[18:3]),
    .generation_i       (s_axis_tdata[82:19]),
    .cmpl_tag_i         (s_axis_tdata[146:83]),
    .epoch_i            (s_axis_tdata[210:147]),
    .time_ns_i          (s_axis_tdata[274:211]),
    .input_seq_i        (s_axis_tdata[338:275]),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (m_axis_tvalid),
    .out_ready_i        (m_axis_tready),
    .tiles_claimed_o    (m_axis_tdata[6:0]),
    .timed_count_o      (m_axis_tdata[13:7]),
    .age_sum_ns_o       (m_axis_tdata[77:14]),
    .oldest_ns_o        (m_axis_tdata[141:78]),
    .newest_ns_o        (m_axis_tdata[205:142]),
    .seq_value_o        (m_axis_tdata[269:206]),
    .seq_valid_o        (m_axis_tuser[0]),
    .set_overflow_o     (m_axis_tuser[1]),
    .last_o             (m_axis_tlast)
  );

  assign m_axis_tdata[271:270] = 2'b00;

endmodule

/* rtl/core/tcca_ctrl.sv */
// Controller state machine of the claim aggregator.
// Depends on tcca_pkg for states, op codes and command/status structs.
module tcca_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_busy_i,
  input  tcca_pkg::sts_t   sts_i,
  output tcca_pkg::cmd_t   cmd_o
);

  tcca_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcca_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tcca_pkg::ST_IDLE: if (in_valid_i) state_d = tcca_pkg::ST_WR_LOOK;
      tcca_pkg::ST_WR_LOOK: begin
        case (sts_i.op)
          tcca_pkg::OP_WRITE:  state_d = tcca_pkg::ST_IDLE;
          tcca_pkg::OP_START:  state_d = tcca_pkg::ST_CLEAR;
          tcca_pkg::OP_CLAIM,
          tcca_pkg::OP_COMMIT: state_d = sts_i.in_range ? tcca_pkg::ST_RD : tcca_pkg::ST_IDLE;
          tcca_pkg::OP_END:    state_d = tcca_pkg::ST_EMIT;
          default:             state_d = tcca_pkg::ST_IDLE;
        endcase
      end
      tcca_pkg::ST_RD: state_d = tcca_pkg::ST_CHECK;
      tcca_pkg::ST_CHECK: begin
        if (sts_i.op == tcca_pkg::OP_COMMIT) begin
          state_d = sts_i.commit_ok ? tcca_pkg::ST_WR_COMMIT : tcca_pkg::ST_IDLE;
        end else begin
          state_d = sts_i.claim_ok ? tcca_pkg::ST_ID_SCAN : tcca_pkg::ST_IDLE;
        end
      end
      tcca_pkg::ST_WR_COMMIT: state_d = tcca_pkg::ST_IDLE;
      tcca_pkg::ST_ID_SCAN: begin
        if (sts_i.id_hit) state_d = tcca_pkg::ST_IDLE;
        else if (sts_i.id_done) state_d = tcca_pkg::ST_ACCUM;
      end
      tcca_pkg::ST_ACCUM: state_d = tcca_pkg::ST_SEQ_SCAN;
      tcca_pkg::ST_SEQ_SCAN: if (sts_i.seq_hit || sts_i.seq_done) state_d = tcca_pkg::ST_IDLE;
      tcca_pkg::ST_CLEAR: if (sts_i.clear_done) state_d = tcca_pkg::ST_IDLE;
      tcca_pkg::ST_EMIT: if (!out_busy_i) state_d = tcca_pkg::ST_EMIT_WAIT;
      tcca_pkg::ST_EMIT_WAIT: state_d = sts_i.emit_last ? tcca_pkg::ST_IDLE : tcca_pkg::ST_EMIT;
      default: state_d = tcca_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tcca_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      tcca_pkg::ST_WR_LOOK: begin
        cmd_o.tbl_wr = (sts_i.op == tcca_pkg::OP_WRITE) && sts_i.in_range;
        cmd_o.start_batch = (sts_i.op == tcca_pkg::OP_START);
        cmd_o.tbl_rd = 1'b1;
      end
      tcca_pkg::ST_WR_COMMIT: cmd_o.tbl_clr = 1'b1;
      tcca_pkg::ST_ID_SCAN: begin
        cmd_o.id_step = !sts_i.id_done && !sts_i.id_hit;
        cmd_o.id_record = sts_i.id_done && !sts_i.id_hit;
      end
      tcca_pkg::ST_ACCUM: cmd_o.accum = 1'b1;
      tcca_pkg::ST_SEQ_SCAN: begin
        cmd_o.seq_step = !sts_i.seq_done && !sts_i.seq_hit;
        cmd_o.seq_record = sts_i.seq_done && !sts_i.seq_hit;
      end
      tcca_pkg::ST_CLEAR: cmd_o.clear_valid = 1'b1;
      tcca_pkg::ST_EMIT: cmd_o.emit_load = !out_busy_i;
      tcca_pkg::ST_EMIT_WAIT: cmd_o.emit_next = 1'b1;
      default: ;
    endcase
  end

endmodule

/* rtl/core/tcca_dp.sv */
// Datapath of the claim aggregator: pending table, dedupe store, sequence list,
// aggregates and output register. Depends on tcca_pkg.
module tcca_dp #(
  parameter int TILE_SLOTS  = 256,
  parameter int CLAIM_SLOTS = 64,
  parameter int SEQ_SLOTS   = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [2:0]     op_i,
  input  logic [15:0]    tile_index_i,
  input  logic [63:0]    generation_i,
  input  logic [63:0]    cmpl_tag_i,
  input  logic [63:0]    epoch_i,
  input  logic [63:0]    time_ns_i,
  input  logic [63:0]    input_seq_i,
  input  tcca_pkg::cmd_t cmd_i,
  output tcca_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [6:0]     tiles_claimed_o,
  output logic [6:0]     timed_count_o,
  output logic [63:0]    age_sum_ns_o,
  output logic [63:0]    oldest_ns_o,
  output logic [63:0]    newest_ns_o,
  output logic [63:0]    seq_value_o,
  output logic           seq_valid_o,
  output logic           set_overflow_o,
  output logic           last_o
);

  localparam int TW = (TILE_SLOTS > 1) ? $clog2(TILE_SLOTS) : 1;
  localparam int CW = $clog2(CLAIM_SLOTS + 1);
  localparam int CI = (CLAIM_SLOTS > 1) ? $clog2(CLAIM_SLOTS) : 1;
  localparam int SW = $clog2(SEQ_SLOTS + 1);
  localparam int SI = (SEQ_SLOTS > 1) ? $clog2(SEQ_SLOTS) : 1;
  localparam int MaxRes = 8;
  localparam int NR = (SEQ_SLOTS < MaxRes) ? SEQ_SLOTS : MaxRes;
  localparam int EW = SW;
  localparam int RowW = 64 * 5;

  // Captured item.
  logic [2:0]  op_q;
  logic [15:0] idx_q;
  logic [63:0] gen_q, cid_q, ep_q, tm_q, sq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= op_i;
      idx_q <= tile_index_i;
      gen_q <= generation_i;
      cid_q <= cmpl_tag_i;
      ep_q  <= epoch_i;
      tm_q  <= time_ns_i;
      sq_q  <= input_seq_i;
    end
  end

  logic in_range;
  assign in_range = ({16'd0, idx_q} < 32'(TILE_SLOTS));
  logic [TW-1:0] tix;
  assign tix = TW'(idx_q);

  // Pending table: one row per tile, valid bit per row stands for reset value.
  logic [RowW-1:0] tbl_mem [TILE_SLOTS];
  logic [TILE_SLOTS-1:0] tbl_vld_q;
  logic [RowW-1:0] row_q;
  logic row_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr) tbl_mem[tix] <= {sq_q, tm_q, ep_q, cid_q, gen_q};
    if (cmd_i.tbl_rd) row_q <= tbl_mem[tix];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q <= '0;
      row_vld_q <= 1'b0;
    end else begin
      if (cmd_i.tbl_wr) tbl_vld_q[tix] <= 1'b1;
      if (cmd_i.tbl_clr) tbl_vld_q[tix] <= 1'b0;
      if (cmd_i.tbl_rd) row_vld_q <= tbl_vld_q[tix];
    end
  end

  logic [63:0] r_gen, r_cid, r_ep, r_tm, r_sq;
  assign r_gen = row_vld_q ? row_q[63:0]    : '0;
  assign r_cid = row_vld_q ? row_q[127:64]  : '0;
  assign r_ep  = row_vld_q ? row_q[191:128] : '0;
  assign r_tm  = row_vld_q ? row_q[255:192] : '0;
  assign r_sq  = row_vld_q ? row_q[319:256] : '0;

  // Batch registers and aggregates.
  logic [63:0] bep_q, ctime_q, age_q, old_q, new_q;
  logic [6:0]  tcnt_q, ccnt_q;
  logic        ovf_q;
  logic [CW-1:0] cfill_q, cptr_q;
  logic [SW-1:0] sfill_q, sptr_q;
  logic [63:0] ids_mem [CLAIM_SLOTS];
  logic [63:0] seq_mem [SEQ_SLOTS];
  logic [63:0] id_rd_q, seq_rd_q;
  logic        id_rd_v_q, seq_rd_v_q;
  logic        clr_q;

  logic id_done, seq_done;
  assign id_done  = (cptr_q == cfill_q) && !id_rd_v_q;
  assign seq_done = (sptr_q == sfill_q) && !seq_rd_v_q;

  // Scans read one entry a cycle; the compare acts on the registered data.
  always_ff @(posedge clk_i) begin
    id_rd_q  <= ids_mem[CI'(cptr_q)];
    seq_rd_q <= seq_mem[SI'(sptr_q)];
    if (cmd_i.id_record && cfill_q < CW'(CLAIM_SLOTS)) ids_mem[CI'(cfill_q)] <= r_cid;
    if (cmd_i.seq_record && sfill_q < SW'(SEQ_SLOTS)) seq_mem[SI'(sfill_q)] <= r_sq;
  end

  logic id_hit, seq_hit;
  assign id_hit  = id_rd_v_q && (id_rd_q == r_cid);
  assign seq_hit = (r_sq == '0) || (seq_rd_v_q && (seq_rd_q == r_sq));

  // Emit index and its sequence read.
  logic [EW-1:0] k_q;
  logic [EW-1:0] n_res;
  assign n_res = (sfill_q == '0) ? EW'(1) :
                 ((sfill_q > SW'(NR)) ? EW'(NR) : EW'(sfill_q));
  logic [63:0] seq_k;
  assign seq_k = seq_mem[SI'(k_q)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bep_q <= '0; ctime_q <= '0; age_q <= '0; old_q <= '0; new_q <= '0;
      tcnt_q <= '0; ccnt_q <= '0; ovf_q <= 1'b0;
      cfill_q <= '0; cptr_q <= '0; sfill_q <= '0; sptr_q <= '0;
      id_rd_v_q <= 1'b0; seq_rd_v_q <= 1'b0; clr_q <= 1'b0; k_q <= '0;
    end else begin
      clr_q <= cmd_i.clear_valid;
      if (cmd_i.start_batch) begin
        bep_q <= ep_q; ctime_q <= tm_q;
        age_q <= '0; old_q <= '0; new_q <= '0;
        tcnt_q <= '0; ccnt_q <= '0; ovf_q <= 1'b0;
        cfill_q <= '0; sfill_q <= '0;
      end
      if (cmd_i.tbl_rd) begin
        cptr_q <= '0; sptr_q <= '0; id_rd_v_q <= 1'b0; seq_rd_v_q <= 1'b0;
      end
      if (cmd_i.id_step) begin
        id_rd_v_q <= (cptr_q != cfill_q);
        if (cptr_q != cfill_q) cptr_q <= cptr_q + CW'(1);
      end
      if (cmd_i.id_record) begin
        if (cfill_q < CW'(CLAIM_SLOTS)) cfill_q <= cfill_q + CW'(1);
        else ovf_q <= 1'b1;
      end
      if (cmd_i.accum) begin
        if (tcnt_q < tcca_pkg::CountMax) tcnt_q <= tcnt_q + 7'd1;
        if (r_tm != '0) begin
          if (ccnt_q < tcca_pkg::CountMax) ccnt_q <= ccnt_q + 7'd1;
          if (ctime_q >= r_tm) age_q <= age_q + (ctime_q - r_tm);
          if (old_q == '0 || r_tm < old_q) old_q <= r_tm;
          if (r_tm > new_q) new_q <= r_tm;
        end
      end
      if (cmd_i.seq_step) begin
        seq_rd_v_q <= (sptr_q != sfill_q);
        if (sptr_q != sfill_q) sptr_q <= sptr_q + SW'(1);
      end
      if (cmd_i.seq_record && sfill_q < SW'(SEQ_SLOTS)) sfill_q <= sfill_q + SW'(1);
      if (cmd_i.load_in) k_q <= '0;
      if (cmd_i.emit_next) k_q <= k_q + EW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      tiles_claimed_o    <= tcnt_q;
      timed_count_o      <= ccnt_q;
      age_sum_ns_o       <= age_q;
      oldest_ns_o        <= old_q;
      newest_ns_o        <= new_q;
      seq_valid_o        <= (EW'(k_q) < EW'(sfill_q));
      seq_value_o        <= (EW'(k_q) < EW'(sfill_q)) ? seq_k : '0;
      set_overflow_o     <= ovf_q;
      last_o             <= (k_q + EW'(1) == n_res);
    end
  end

  // The index still holds the result just loaded; the run ends when it was the final one.
  assign sts_o.in_range   = in_range;
  assign sts_o.claim_ok   = (r_cid != '0) && (r_gen == gen_q) && (r_ep == bep_q);
  assign sts_o.commit_ok  = (r_cid != '0) && (r_gen == gen_q) && (r_ep == ep_q);
  assign sts_o.id_done    = id_done;
  assign sts_o.id_hit     = id_hit;
  assign sts_o.seq_done   = seq_done;
  assign sts_o.seq_hit    = seq_hit;
  assign sts_o.emit_last  = (k_q + EW'(1) == n_res);
  assign sts_o.clear_done = clr_q;
  assign sts_o.op         = tcca_pkg::op_e'(op_q);

endmodule

/* test/tile_completion_claim_aggregator_core_tb.sv */
// Self-checking testbench for the tile completion claim aggregator core.
// Drives op transfers with random gaps and predicts batch-end summaries in a scoreboard class.
// Depends on tcca_pkg and tile_completion_claim_aggregator_core.
module tile_completion_claim_aggregator_core_tb;

  localparam int NTILE = 256;
  localparam int NCLAIM = 64;
  localparam int NSEQ = 8;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [6:0]  tiles_claimed;
    logic [6:0]  timed_count;
    logic [63:0] age_sum;
    logic [63:0] oldest;
    logic [63:0] newest;
    logic [63:0] seq_value;
    logic        seq_valid;
    logic        overflow;
    logic        last;
  } summary_t;

  int errors = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  class claim_scoreboard;
    logic [63:0] tbl_id[NTILE], tbl_gen[NTILE], tbl_epoch[NTILE];
    logic [63:0] tbl_done[NTILE], tbl_seq[NTILE];
    logic [63:0] ids[NCLAIM];
    int          id_fill;
    logic [63:0] seqs[NSEQ];
    int          seq_fill;
    logic [63:0] batch_epoch, claim_time;
    logic [6:0]  n_tiles, n_done;
    logic [63:0] age_sum, oldest, newest;
    logic        overflow;
    summary_t    pending[$];

    function new();
      for (int i = 0; i < NTILE; i++) begin
        tbl_id[i] = 0; tbl_gen[i] = 0; tbl_epoch[i] = 0; tbl_done[i] = 0; tbl_seq[i] = 0;
      end
      batch_epoch = 0;
      claim_time = 0;
      clear_batch();
    endfunction

    function void clear_batch();
      id_fill = 0; seq_fill = 0; n_tiles = 0; n_done = 0;
      age_sum = 0; oldest = 0; newest = 0; overflow = 0;
    endfunction

    function void do_claim(logic [7:0] t, logic [63:0] gen);
      logic [63:0] d;
      bit          seen;
      if (tbl_id[t] == 0 || tbl_gen[t] != gen || tbl_epoch[t] != batch_epoch) return;
      seen = 0;
      for (int i = 0; i < id_fill; i++) if (ids[i] == tbl_id[t]) seen = 1;
      if (seen) return;
      if (id_fill < NCLAIM) ids[id_fill++] = tbl_id[t];
      else overflow = 1;
      if (n_tiles != tcca_pkg::CountMax) n_tiles++;
      d = tbl_done[t];
      if (d != 0) begin
        if (n_done != tcca_pkg::CountMax) n_done++;
        if (claim_time >= d) age_sum += claim_time - d;
        if (oldest == 0 || d < oldest) oldest = d;
        if (d > newest) newest = d;
      end
      if (tbl_seq[t] != 0) begin
        seen = 0;
        for (int i = 0; i < seq_fill; i++) if (seqs[i] == tbl_seq[t]) seen = 1;
        if (!seen && seq_fill < NSEQ) seqs[seq_fill++] = tbl_seq[t];
      end
    endfunction

    function void note_input(logic [343:0] d);
      logic [2:0]  op;
      logic [15:0] idx;
      logic [7:0]  t;
      logic [63:0] gen, cid, ep, tm, sq;
      summary_t    s;
      int          n;
      bit          ok;
      op = d[2:0]; idx = d[18:3]; gen = d[82:19]; cid = d[146:83];
      ep = d[210:147]; tm = d[274:211]; sq = d[338:275];
      ok = idx < NTILE;
      t = idx[7:0];
      case (op)
        tcca_pkg::OP_WRITE: if (ok) begin
          tbl_gen[t] = gen; tbl_id[t] = cid; tbl_epoch[t] = ep;
          tbl_done[t] = tm; tbl_seq[t] = sq;
        end
        tcca_pkg::OP_START: begin
          batch_epoch = ep; claim_time = tm; clear_batch();
        end
        tcca_pkg::OP_CLAIM: if (ok) do_claim(t, gen);
        tcca_pkg::OP_END: begin
          n = (seq_fill == 0) ? 1 : seq_fill;
          for (int k = 0; k < n; k++) begin
            s.tiles_claimed = n_tiles; s.timed_count = n_done;
            s.age_sum = age_sum; s.oldest = oldest; s.newest = newest;
            s.seq_valid = k < seq_fill;
            s.seq_value = s.seq_valid ? seqs[k] : 64'd0;
            s.overflow = overflow; s.last = (k == n - 1);
            pending.push_back(s);
          end
        end
        tcca_pkg::OP_COMMIT: if (ok && tbl_epoch[t] == ep && tbl_id[t] != 0 && tbl_gen[t] == gen)
        begin
          tbl_id[t] = 0; tbl_gen[t] = 0; tbl_epoch[t] = 0;
          tbl_done[t] = 0; tbl_seq[t] = 0;
        end
        default: ;
      endcase
    endfunction

    task check_result(logic [271:0] d, logic [1:0] u, logic l);
      summary_t w;
      if (pending.size() == 0) begin
        report("unexpected transfer", d[63:0], 0);
        return;
      end
      w = pending.pop_front();
      if (d[6:0] != w.tiles_claimed) report("tiles_claimed", d[6:0], w.tiles_claimed);
      if (d[13:7] != w.timed_count) report("timed_count", d[13:7], w.timed_count);
      if (d[77:14] != w.age_sum) report("age_sum_ns", d[77:14], w.age_sum);
      if (d[141:78] != w.oldest) report("oldest_ns", d[141:78], w.oldest);
      if (d[205:142] != w.newest) report("newest_ns", d[205:142], w.newest);
      if (d[269:206] != w.seq_value) report("seq_value", d[269:206], w.seq_value);
      if (u[0] != w.seq_valid) report("seq_valid", u[0], w.seq_valid);
      if (u[1] != w.overflow) report("set_overflow", u[1], w.overflow);
      if (l != w.last) report("tlast", l, w.last);
    endtask
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [343:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [271:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  tile_completion_claim_aggregator_core uut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  claim_scoreboard sb = new();
  bit  no_gaps = 0;
  bit  hold_sink = 0;
  int  quiet = 0;

  // Live slots and values reused so claims match entries.
  logic [63:0] epochs[4] = '{64'd0, 64'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1234};

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [343:0] pack_item(logic [2:0] op, logic [15:0] idx,
      logic [63:0] gen, logic [63:0] cid, logic [63:0] ep, logic [63:0] tm, logic [63:0] sq);
    return {5'd0, sq, tm, ep, cid, gen, idx, op};
  endfunction

  // The valid line stays up after a transfer so that the next one can follow at once;
  // a gap or a wait drops it first.
  task automatic send(input logic [343:0] d);
    while (!no_gaps && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tdata <= d;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(d);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // Small tile range and id pool so matches and duplicates are frequent.
  task automatic random_item(input int ep_sel);
    logic [2:0]  op;
    logic [15:0] idx;
    int          r;
    r = $urandom_range(99);
    idx = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(15));
    if (r < 35) op = tcca_pkg::OP_WRITE;
    else if (r < 75) op = tcca_pkg::OP_CLAIM;
    else if (r < 82) op = tcca_pkg::OP_START;
    else if (r < 90) op = tcca_pkg::OP_END;
    else if (r < 97) op = tcca_pkg::OP_COMMIT;
    else op = 3'($urandom_range(7, 5));
    send(pack_item(op, idx, 64'($urandom_range(2)),
        ($urandom_range(9) == 0) ? rnd64() : 64'($urandom_range(12)),
        ($urandom_range(9) == 0) ? rnd64() : epochs[ep_sel],
        ($urandom_range(4) == 0) ? rnd64() : 64'($urandom_range(1000)),
        ($urandom_range(4) == 0) ? rnd64() : 64'($urandom_range(10))));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("tile_completion_claim_aggregator_core_tb: FAIL");
        $finish;
      end
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= !hold_sink && (no_gaps || $urandom_range(99) >= 29);

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // Directed: empty batch, extremes, out-of-range slot, unused op code.
    send(pack_item(tcca_pkg::OP_END, 0, 0, 0, 0, 0, 0));
    send(pack_item(tcca_pkg::OP_CLAIM, 0, 0, 0, 0, 0, 0));
    send(pack_item(tcca_pkg::OP_WRITE, 255, '1, '1, '1, '1, '1));
    send(pack_item(tcca_pkg::OP_WRITE, 16'hFFFF, '1, 5, '1, 1, 1));
    send(pack_item(tcca_pkg::OP_START, 0, 0, 0, '1, '1, 0));
    send(pack_item(tcca_pkg::OP_CLAIM, 255, '1, 0, 0, 0, 0));
    send(pack_item(tcca_pkg::OP_CLAIM, 255, '1, 0, 0, 0, 0));
    send(pack_item(tcca_pkg::OP_CLAIM, 16'hFFFF, '1, 0, 0, 0, 0));
    send(pack_item(tcca_pkg::OP_END, 0, 0, 0, 0, 0, 0));
    send(pack_item(tcca_pkg::OP_COMMIT, 255, '1, 0, '1, 0, 0));
    send(pack_item(3'd7, 0, 0, 0, 0, 0, 0));
    send(pack_item(tcca_pkg::OP_END, 0, 0, 0, 0, 0, 0));
    drain();
    // Offer more distinct sequences than the list holds, with no gaps.
    send(pack_item(tcca_pkg::OP_START, 0, 0, 0, 64'd3, 64'd500, 0));
    no_gaps = 1;
    for (int i = 0; i < 12; i++) begin
      send(pack_item(tcca_pkg::OP_WRITE, 16'(i % 10), 0, 64'(100 + i), 3, 64'(i * 60),
          64'(i % 12)));
      send(pack_item(tcca_pkg::OP_CLAIM, 16'(i % 10), 0, 0, 0, 0, 0));
    end
    no_gaps = 0;
    send(pack_item(tcca_pkg::OP_END, 0, 0, 0, 0, 0, 0));
    drain();
    // Backpressure: receiver holds off while batch ends keep coming.
    fork
      begin
        hold_sink = 1;
        repeat (300) @(negedge clk_i);
        hold_sink = 0;
      end
      for (int i = 0; i < 6; i++) send(pack_item(tcca_pkg::OP_END, 0, 0, 0, 0, 0, 0));
    join
    drain();
    // Random batches, each with an epoch drawn from the epoch list.
    for (int b = 0; b < 11; b++) begin
      int e;
      e = $urandom_range(3);
      no_gaps = (b == 5);
      send(pack_item(tcca_pkg::OP_START, 0, 0, 0, epochs[e], 64'($urandom_range(1200)), 0));
      for (int i = 0; i < 9; i++) random_item(e);
      send(pack_item(tcca_pkg::OP_END, 0, 0, 0, 0, 0, 0));
      if (b % 4 == 3) drain();
    end
    no_gaps = 0;
    drain();
    if (errors == 0) $display("tile_completion_claim_aggregator_core_tb: PASS");
    else $display("tile_completion_claim_aggregator_core_tb: FAIL");
    $finish;
  end
endmodule

/* sim.f */
rtl/core/tcca_pkg.sv
rtl/core/tcca_ctrl.sv
rtl/core/tcca_dp.sv
rtl/core/tile_completion_claim_aggregator_core.sv
test/tile_completion_claim_aggregator_core_tb.sv
